// ----- src/fne_pkg.sv -----
// ----------------------------------------------------------------------------
// fne_pkg: shared types and constants for the FitzHugh-Nagumo cell bank
// Field widths, register indexes, step phase codes and the control word that
// the sequencer hands to the arithmetic unit.
// ----------------------------------------------------------------------------
package fne_pkg;

	localparam int CELL_COUNT_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 24;

	localparam int IDX_W      = 10;   // cell index field
	localparam int IDX_WIDE_W = 17;   // holds any legal cell count
	localparam int VAL_W      = 32;   // Q8.24 membrane / recovery / stimulus
	localparam int DT_W       = 25;   // time_step register
	localparam int STEPS_W    = 11;   // steps_per_call register
	localparam int CFG_IDX_W  = 2;
	localparam int S_DATA_W   = 48;   // 10 + 32, padded to bytes
	localparam int M_DATA_W   = 80;   // 10 + 32 + 32, padded to bytes

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 2'd1;

	localparam logic [DT_W-1:0]    DT_RESET    = 25'd167772;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd1;

	// One Euler step is seventeen phases on the shared unit.
	localparam int PH_W = 5;
	localparam logic [PH_W-1:0] PH_OMU    = 5'd0;   // 1 - u
	localparam logic [PH_W-1:0] PH_UMA    = 5'd1;   // u - a
	localparam logic [PH_W-1:0] PH_MUL_UV = 5'd2;
	localparam logic [PH_W-1:0] PH_RND_UV = 5'd3;
	localparam logic [PH_W-1:0] PH_MUL_UO = 5'd4;
	localparam logic [PH_W-1:0] PH_RND_UO = 5'd5;
	localparam logic [PH_W-1:0] PH_MUL_CU = 5'd6;
	localparam logic [PH_W-1:0] PH_RND_IN = 5'd7;
	localparam logic [PH_W-1:0] PH_MUL_K  = 5'd8;
	localparam logic [PH_W-1:0] PH_RND_DU = 5'd9;
	localparam logic [PH_W-1:0] PH_MUL_BU = 5'd10;
	localparam logic [PH_W-1:0] PH_RND_BV = 5'd11;
	localparam logic [PH_W-1:0] PH_MUL_KE = 5'd12;
	localparam logic [PH_W-1:0] PH_RND_DV = 5'd13;
	localparam logic [PH_W-1:0] PH_MUL_DU = 5'd14;
	localparam logic [PH_W-1:0] PH_RND_NU = 5'd15;
	localparam logic [PH_W-1:0] PH_RND_NV = 5'd16;  // v update closes the step
	localparam logic [PH_W-1:0] PH_LAST   = 5'd16;

	typedef struct packed {
		logic            load;    // take u, v from the store, clear the clip flag
		logic            step;    // run one phase
		logic [PH_W-1:0] phase;
	} fne_ctl_t;

endpackage

// ----- src/fitzhugh_nagumo_euler_cells.sv -----
// ----------------------------------------------------------------------------
// fitzhugh_nagumo_euler_cells: bank of FitzHugh-Nagumo cells, forward Euler
// Each transfer names a cell and a stimulus; the cell is advanced by
// steps_per_call Euler steps in saturating Q8.24 and its new state reported.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   cell_index, stimulus
//  m_axis    out        m_axis_tvalid/m_axis_tready   cell, u, v / saturated
//  cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
//  An in-range cell goes from accept through load, steps_per_call Euler steps
//  and handoff to the result register; an out-of-range cell or zero steps
//  skips from load to handoff. Each step runs through the phases of the one
//  shared multiplier and adder. After reset the state memory is swept to zero
//  and s_axis_tready stays low meanwhile; cfg writes are taken at any time.
//  The next item is accepted while a result waits in the output register; a
//  finished item holds in its last state until that register is free.
// ----------------------------------------------------------------------------
module fitzhugh_nagumo_euler_cells
	import fne_pkg::*;
#(
	parameter int CELL_COUNT = CELL_COUNT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_DATA_W-1:0]   s_axis_tdata,   // cell_index[9:0], stimulus[41:10]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_DATA_W-1:0]   m_axis_tdata,   // cell_out[9:0], membrane_out[41:10],
	                                              // recovery_out[73:42]
	output logic [0:0]            m_axis_tuser,   // saturated[0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DT_W-1:0]       cfg_data
);

	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_STEP = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// configuration
	logic [DT_W-1:0]    dt_q;
	logic [STEPS_W-1:0] steps_q;

	// sequencer
	logic [1:0]         state_q;
	logic [PH_W-1:0]    phase_q;
	logic [STEPS_W-1:0] cnt_q;

	// item registers
	logic [IDX_W-1:0]        cell_q;
	logic [AW-1:0]           addr_q;
	logic signed [VAL_W-1:0] stim_q;
	logic                    in_range_q;

	// output register
	logic                    m_valid_q;
	logic [IDX_W-1:0]        m_cell_q;
	logic [VAL_W-1:0]        m_u_q, m_v_q;
	logic                    m_sat_q;

	logic [IDX_W-1:0]        s_cell;
	logic signed [VAL_W-1:0] s_stim;
	logic [IDX_WIDE_W-1:0]   s_idx_wide;
	logic                    s_fire, out_load, store_busy;
	logic [2*VAL_W-1:0]      rd_data;
	logic signed [VAL_W-1:0] ld_u, ld_v, unit_u, unit_v;
	logic                    unit_sat;
	fne_ctl_t                ctl;

	assign s_cell     = s_axis_tdata[IDX_W-1:0];
	assign s_stim     = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
	assign s_idx_wide = IDX_WIDE_W'(s_cell);

	assign s_axis_tready = (state_q == ST_IDLE) && !store_busy;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);
	assign cfg_ready     = 1'b1;

	// register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q    <= DT_RESET;
			steps_q <= STEPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIME_STEP: dt_q    <= cfg_data;
				REG_STEPS:     steps_q <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: accept, load from the store, run the step phases, hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_OMU;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// a handoff refills the output register, else a taken result empties it
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						cnt_q   <= steps_q;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					phase_q <= PH_OMU;
					// skip the steps for a cell outside the bank or a zero count
					if (!in_range_q || cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (phase_q == PH_LAST) begin
						phase_q <= PH_OMU;
						cnt_q   <= cnt_q - STEPS_W'(1);
						if (cnt_q == STEPS_W'(1)) begin
							state_q <= ST_FIN;
						end
					end else begin
						phase_q <= phase_q + PH_W'(1);
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cell_q     <= s_cell;
			addr_q     <= s_idx_wide[AW-1:0];
			stim_q     <= s_stim;
			in_range_q <= s_idx_wide < IDX_WIDE_W'(CELL_COUNT);
		end
		if (out_load) begin
			m_cell_q <= cell_q;
			m_u_q    <= unit_u;
			m_v_q    <= unit_v;
			m_sat_q  <= unit_sat;
		end
	end

	// out-of-range cells report zero state
	assign ld_u = in_range_q ? rd_data[VAL_W-1:0] : '0;
	assign ld_v = in_range_q ? rd_data[2*VAL_W-1:VAL_W] : '0;

	always_comb begin
		ctl.load  = (state_q == ST_LOAD);
		ctl.step  = (state_q == ST_STEP);
		ctl.phase = phase_q;
	end

	fne_store #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_fire),
		.rd_addr (s_idx_wide[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (out_load && in_range_q),
		.wr_addr (addr_q),
		.wr_data ({unit_v, unit_u}),
		.busy    (store_busy)
	);

	fne_unit #(
		.FRAC_BITS (FRAC_BITS)
	) u_unit (
		.clk    (clk),
		.ctl    (ctl),
		.load_u (ld_u),
		.load_v (ld_v),
		.stim   (stim_q),
		.dt     (dt_q),
		.u      (unit_u),
		.v      (unit_v),
		.sat    (unit_sat)
	);

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = {(M_DATA_W - IDX_W - 2*VAL_W)'(0), m_v_q, m_u_q, m_cell_q};
	assign m_axis_tuser[0] = m_sat_q;

	// no input during the clearing sweep
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> !s_axis_tready)
		else $error("input ready while state memory is being cleared");

	// step phases only run with steps left
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (cnt_q != '0))
		else $error("step phase with zero steps remaining");

	// a handed-off result shows on the output next cycle
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("result handoff did not raise m_axis_tvalid");

	// an out-of-range cell goes straight to handoff
	a_range_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && !in_range_q) |=> (state_q == ST_FIN))
		else $error("out-of-range cell entered the step phases");

endmodule

// ----- src/fne_store.sv -----
// ----------------------------------------------------------------------------
// fne_store: cell state memory
// One word per cell holding {recovery, membrane}. One write and one registered
// read per cycle. After reset a sweep writes zero to every entry.
// ----------------------------------------------------------------------------
module fne_store
	import fne_pkg::*;
#(
	parameter int DEPTH = CELL_COUNT_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [2*VAL_W-1:0]   rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [2*VAL_W-1:0]   wr_data,
	output logic                 busy
);

	logic [2*VAL_W-1:0] mem [DEPTH];
	logic [2*VAL_W-1:0] rd_data_q;
	logic [AW-1:0]      clr_addr_q;
	logic               busy_q;

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// ----- src/fne_unit.sv -----
// ----------------------------------------------------------------------------
// fne_unit: shared multiply / round / saturating add unit
// Holds u, v and the step temporaries. A phase registers a product, adds one
// operand to 1, u or the rounded last product and saturates, or does both.
// ----------------------------------------------------------------------------
module fne_unit
	import fne_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  fne_ctl_t                ctl,
	input  logic signed [VAL_W-1:0] load_u,
	input  logic signed [VAL_W-1:0] load_v,
	input  logic signed [VAL_W-1:0] stim,
	input  logic [DT_W-1:0]         dt,
	output logic signed [VAL_W-1:0] u,
	output logic signed [VAL_W-1:0] v,
	output logic                    sat
);

	localparam int OPW = VAL_W + 1;     // operand width, holds unsigned dt too
	localparam int PW  = 2 * OPW;       // product width
	localparam int SW  = OPW + 1;       // sum width

	localparam longint ONE_L  = longint'(1) << FRAC_BITS;
	localparam longint A_L    = (ONE_L + 2) / 5;
	localparam longint B_L    = longint'(1) << (FRAC_BITS - 1);
	localparam longint KEPS_L = ((longint'(27) << FRAC_BITS) + 2500) / 5000;

	localparam logic signed [OPW-1:0] C_ONE  = OPW'(ONE_L);
	localparam logic signed [OPW-1:0] C_A    = OPW'(A_L);
	localparam logic signed [OPW-1:0] C_B    = OPW'(B_L);
	localparam logic signed [OPW-1:0] C_KEPS = OPW'(KEPS_L);
	localparam logic signed [OPW-1:0] C_K    = OPW'(36);
	localparam logic signed [PW-1:0]  C_HALF = PW'(B_L);

	localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;
	localparam logic signed [PW-1:0]    P_MAX = PW'(V_MAX);
	localparam logic signed [PW-1:0]    P_MIN = PW'(V_MIN);

	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_OMU  = 3'd1;
	localparam logic [2:0] DST_UMA  = 3'd2;
	localparam logic [2:0] DST_T1   = 3'd3;
	localparam logic [2:0] DST_T2   = 3'd4;
	localparam logic [2:0] DST_U    = 3'd5;
	localparam logic [2:0] DST_V    = 3'd6;

	logic signed [VAL_W-1:0] u_q, v_q, t1_q, t2_q, omu_q, uma_q;
	logic                    sat_q;
	logic signed [PW-1:0]    prod_q;

	logic signed [OPW-1:0]   op_a, op_b, add_x, add_y, sum_x;
	logic                    raw, add_only, chk_prod, chk_sum;
	logic [2:0]              dst;
	logic signed [PW-1:0]    rsum, rfull, pick;
	logic                    p_hi, p_lo, s_hi, s_lo;
	logic signed [VAL_W-1:0] prod_sat, res;
	logic signed [SW-1:0]    sum_w;

	always_comb begin
		op_a     = '0;
		op_b     = '0;
		add_x    = '0;
		add_y    = '0;
		raw      = 1'b0;
		add_only = 1'b0;
		chk_prod = 1'b0;
		chk_sum  = 1'b0;
		dst      = DST_NONE;
		case (ctl.phase)
			PH_OMU: begin
				add_only = 1'b1;
				add_x    = C_ONE;
				add_y    = -OPW'(u_q);
				chk_sum  = 1'b1;
				dst      = DST_OMU;
			end
			PH_UMA: begin
				add_only = 1'b1;
				add_x    = OPW'(u_q);
				add_y    = -C_A;
				chk_sum  = 1'b1;
				dst      = DST_UMA;
			end
			PH_MUL_UV: begin
				op_a = OPW'(u_q);
				op_b = OPW'(v_q);
			end
			PH_RND_UV: begin
				chk_prod = 1'b1;
				dst      = DST_T2;
			end
			PH_MUL_UO: begin
				op_a = OPW'(u_q);
				op_b = OPW'(omu_q);
			end
			PH_RND_UO: begin
				chk_prod = 1'b1;
				dst      = DST_T1;
			end
			PH_MUL_CU: begin
				op_a = OPW'(t1_q);
				op_b = OPW'(uma_q);
			end
			PH_RND_IN: begin
				// cubic term minus u*v
				chk_prod = 1'b1;
				add_y    = -OPW'(t2_q);
				chk_sum  = 1'b1;
				dst      = DST_T1;
			end
			PH_MUL_K: begin
				op_a = C_K;
				op_b = OPW'(t1_q);
			end
			PH_RND_DU: begin
				// integer gain: no rounding shift
				raw      = 1'b1;
				chk_prod = 1'b1;
				add_y    = OPW'(stim);
				chk_sum  = 1'b1;
				dst      = DST_T1;
			end
			PH_MUL_BU: begin
				op_a = C_B;
				op_b = OPW'(u_q);
			end
			PH_RND_BV: begin
				chk_prod = 1'b1;
				add_y    = -OPW'(v_q);
				chk_sum  = 1'b1;
				dst      = DST_T2;
			end
			PH_MUL_KE: begin
				op_a = C_KEPS;
				op_b = OPW'(t2_q);
			end
			PH_RND_DV: begin
				chk_prod = 1'b1;
				dst      = DST_T2;
			end
			PH_MUL_DU: begin
				op_a = OPW'(dt);
				op_b = OPW'(t1_q);
			end
			PH_RND_NU: begin
				// u update and dt*dv product share this phase
				chk_prod = 1'b1;
				add_y    = OPW'(u_q);
				chk_sum  = 1'b1;
				dst      = DST_U;
				op_a     = OPW'(dt);
				op_b     = OPW'(t2_q);
			end
			PH_RND_NV: begin
				chk_prod = 1'b1;
				add_y    = OPW'(v_q);
				chk_sum  = 1'b1;
				dst      = DST_V;
			end
			default: begin
				dst = DST_NONE;
			end
		endcase
	end

	// round to nearest (floor after adding half), then saturate
	assign rsum  = prod_q + C_HALF;
	assign rfull = rsum >>> FRAC_BITS;
	assign pick  = raw ? prod_q : rfull;
	assign p_hi  = pick > P_MAX;
	assign p_lo  = pick < P_MIN;

	always_comb begin
		if (p_hi) begin
			prod_sat = V_MAX;
		end else if (p_lo) begin
			prod_sat = V_MIN;
		end else begin
			prod_sat = pick[VAL_W-1:0];
		end
	end

	assign sum_x = add_only ? add_x : OPW'(prod_sat);
	assign sum_w = SW'(sum_x) + SW'(add_y);
	assign s_hi  = sum_w > SW'(V_MAX);
	assign s_lo  = sum_w < SW'(V_MIN);

	always_comb begin
		if (s_hi) begin
			res = V_MAX;
		end else if (s_lo) begin
			res = V_MIN;
		end else begin
			res = sum_w[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (ctl.load) begin
			u_q   <= load_u;
			v_q   <= load_v;
			sat_q <= 1'b0;
		end else if (ctl.step) begin
			sat_q <= sat_q | (chk_prod & (p_hi | p_lo)) | (chk_sum & (s_hi | s_lo));
			case (dst)
				DST_OMU: omu_q <= res;
				DST_UMA: uma_q <= res;
				DST_T1:  t1_q  <= res;
				DST_T2:  t2_q  <= res;
				DST_U:   u_q   <= res;
				DST_V:   v_q   <= res;
				default: ;
			endcase
		end
	end

	assign u   = u_q;
	assign v   = v_q;
	assign sat = sat_q;

endmodule

// ----- tb/fitzhugh_nagumo_euler_cells_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitzhugh_nagumo_euler_cells_test: self-checking bench for the cell bank
// Streams (cell, stimulus) transfers into the block and keeps a shadow copy
// of every cell's membrane and recovery values. Each accepted transfer is
// advanced in the bench with the same saturating fixed-point Euler steps, and
// each result transfer is compared field by field with the oldest prediction.
// Register settings change between batches, only while the block is drained.
// ----------------------------------------------------------------------------
module fitzhugh_nagumo_euler_cells_test;
	import fne_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;     // block is idle once its last result is out
	localparam int BATCH_ITEMS   = 105;
	localparam int BATCHES       = 8;

	// register indexes that decode to nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	// fixed-point constants of the cell model
	localparam longint FX_ONE    = longint'(1) << FRAC_BITS_DEF;
	localparam longint FX_HALF   = FX_ONE >> 1;                 // rounding offset
	localparam longint FX_A      = (FX_ONE + 2) / 5;            // 0.2
	localparam longint FX_B      = FX_ONE >> 1;                 // 0.5
	localparam longint FX_K      = 36;
	localparam longint FX_KEPS   = ((longint'(27) << FRAC_BITS_DEF) + 2500) / 5000;
	localparam longint S32_MAX   = 64'sd2147483647;
	localparam longint S32_MIN   = -64'sd2147483648;

	localparam logic signed [VAL_W-1:0] STIM_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VAL_W-1:0] STIM_MIN = 32'sh80000000;
	localparam logic signed [VAL_W-1:0] STIM_ONE = 32'sh01000000;

	typedef struct packed {
		logic [IDX_W-1:0]        cell_idx;
		logic signed [VAL_W-1:0] stim;
	} cell_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        cell_idx;
		logic signed [VAL_W-1:0] u;
		logic signed [VAL_W-1:0] v;
		logic                    sat;
	} cell_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata = '0;    // cell_index[9:0], stimulus[41:10]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_axis_tdata;         // cell_out[9:0], membrane_out[41:10],
	                                            // recovery_out[73:42]
	logic [0:0]           m_axis_tuser;         // saturated[0]
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DT_W-1:0]      cfg_data = '0;

	// shadow of the block: cell bank and registers
	int               membrane_mem [CELL_COUNT_DEF];
	int               recovery_mem [CELL_COUNT_DEF];
	logic [DT_W-1:0]    dt_reg    = DT_RESET;
	logic [STEPS_W-1:0] steps_reg = STEPS_RESET;
	bit               clip_hit;

	cell_item_t  queued_stimuli[$];    // waiting to be offered to the block
	cell_state_t awaited_states[$];    // predicted results, oldest first
	cell_item_t  on_bus;
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          long_hold_done = 1'b0;
	bit          calm = 1'b0;           // no idling on either side
	int          fail_count = 0;

	always #(CLK_HALF) clk = ~clk;

	fitzhugh_nagumo_euler_cells DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Clamp to the signed 32-bit range and note any clipping.
	function automatic longint clip32(input longint x);
		if (x > S32_MAX) begin
			clip_hit = 1'b1;
			return S32_MAX;
		end
		if (x < S32_MIN) begin
			clip_hit = 1'b1;
			return S32_MIN;
		end
		return x;
	endfunction

	// Exact product, round half up to FRAC_BITS fraction bits, then clamp.
	function automatic longint qmul(input longint x, input longint y);
		return clip32((x * y + FX_HALF) >>> FRAC_BITS_DEF);
	endfunction

	// Run the configured number of Euler steps on one cell, update the
	// shadow bank and queue the state the block must report.
	function automatic void advance_cell(input cell_item_t it);
		cell_state_t r;
		longint u, v, omu, uma, cub, uv, inner, du, dv, nu, nv, dt, stim;
		r = '0;
		r.cell_idx = it.cell_idx;
		clip_hit = 1'b0;
		if (it.cell_idx < CELL_COUNT_DEF) begin
			u = membrane_mem[it.cell_idx];
			v = recovery_mem[it.cell_idx];
			dt = longint'(dt_reg);
			stim = longint'(it.stim);
			repeat (steps_reg) begin
				omu = clip32(FX_ONE - u);
				uma = clip32(u - FX_A);
				cub = qmul(qmul(u, omu), uma);
				uv = qmul(u, v);
				inner = clip32(cub - uv);
				du = clip32(clip32(FX_K * inner) + stim);
				dv = qmul(FX_KEPS, clip32(qmul(FX_B, u) - v));
				nu = clip32(qmul(dt, du) + u);
				nv = clip32(qmul(dt, dv) + v);
				u = nu;
				v = nv;
			end
			membrane_mem[it.cell_idx] = int'(u);
			recovery_mem[it.cell_idx] = int'(v);
			r.u = u[VAL_W-1:0];
			r.v = v[VAL_W-1:0];
			r.sat = clip_hit;
		end
		awaited_states.push_back(r);
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	function automatic void check_state(input cell_state_t got);
		cell_state_t want;
		if (awaited_states.size() == 0) begin
			$error("result for cell %0d with no prediction waiting", got.cell_idx);
			fail_count++;
			return;
		end
		want = awaited_states.pop_front();
		if (got.cell_idx !== want.cell_idx) begin
			$error("cell_out: expected %0d, actual %0d", want.cell_idx, got.cell_idx);
			fail_count++;
		end
		if (got.u !== want.u) begin
			$error("membrane_out: expected %0d, actual %0d", want.u, got.u);
			fail_count++;
		end
		if (got.v !== want.v) begin
			$error("recovery_out: expected %0d, actual %0d", want.v, got.v);
			fail_count++;
		end
		if (got.sat !== want.sat) begin
			$error("saturated: expected %0d, actual %0d", want.sat, got.sat);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offer queued stimuli; predict each one at its transfer.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_idle = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				advance_cell(on_bus);
			// the bus slot is free when nothing is offered or the offer was taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_idle > 0) begin
					send_idle--;
					s_axis_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					// start an idle burst, this one included; send_idle holds the idle slots to come
					send_idle = $urandom_range(0, 4);
					s_axis_tvalid <= 1'b0;
				end else if (queued_stimuli.size() != 0) begin
					on_bus = queued_stimuli.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(S_DATA_W-IDX_W-VAL_W){1'b0}}, on_bus.stim,
					                 on_bus.cell_idx};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: take results, check them, and stall the output at random.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_state({m_axis_tdata[IDX_W-1:0],
				             m_axis_tdata[IDX_W+VAL_W-1:IDX_W],
				             m_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W],
				             m_axis_tuser[0]});
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && queued_stimuli.size() > 60) begin
				// hold off long enough for the block to back up and stall its input
				long_hold_done = 1'b1;
				recv_stall = 400;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				recv_stall = $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and configuration
	// ------------------------------------------------------------------------

	// Write one register and mirror the effect in the shadow copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TIME_STEP)
			dt_reg = val;
		else if (idx == REG_STEPS)
			steps_reg = val[STEPS_W-1:0];
	endtask

	// Hold until every queued stimulus has transferred and every result is in.
	// Sample on the falling edge so that the driver's rising-edge updates are seen.
	task automatic drain();
		while (queued_stimuli.size() != 0 || awaited_states.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_item(input logic [IDX_W-1:0] cell_idx,
	                                  input logic signed [VAL_W-1:0] stim);
		queued_stimuli.push_back('{cell_idx: cell_idx, stim: stim});
	endfunction

	// Mostly a small set of busy cells with plausible currents, so that the
	// cells go through whole spike cycles; the rest is anything goes.
	function automatic cell_item_t random_item();
		cell_item_t it;
		if ($urandom_range(0, 3) == 0)
			it.cell_idx = IDX_W'($urandom_range(0, CELL_COUNT_DEF - 1));
		else
			it.cell_idx = IDX_W'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0:       it.stim = '0;
			1:       it.stim = $urandom_range(0, 1) ? STIM_MAX : STIM_MIN;
			2, 3:    it.stim = $urandom();
			default: it.stim = int'($urandom_range(0, 1 << 25)) - (1 << 24);
		endcase
		return it;
	endfunction

	// Step size for a random batch: the extremes now and then, else typical.
	function automatic logic [DT_W-1:0] random_dt();
		logic [DT_W-1:0] d;
		case ($urandom_range(0, 5))
			0:       d = 25'h1000000;
			1:       d = 25'h1FFFFFF;
			2:       d = DT_W'($urandom());
			default: d = DT_W'($urandom_range(80000, 1700000));
		endcase
		return d;
	endfunction

	initial begin
		logic [DT_W-1:0] steps_word;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero cells, extreme currents, one cell pushed repeatedly
		push_item(10'd0, '0);
		push_item(10'd1023, STIM_MAX);
		push_item(10'd1023, STIM_MAX);
		push_item(10'd0, STIM_MIN);
		push_item(10'd0, STIM_MIN);
		push_item(10'd5, STIM_ONE);
		push_item(10'd5, STIM_ONE);
		push_item(10'd5, -STIM_ONE);
		drain();

		// zero steps and zero step size: cells report their stored values;
		// the upper data bits must be dropped by the step count register
		write_reg(REG_TIME_STEP, '0);
		write_reg(REG_STEPS, 25'h1FFF800);
		push_item(10'd5, STIM_ONE);
		push_item(10'd1023, '0);
		push_item(10'd0, STIM_MAX);
		drain();

		// step size of exactly one
		write_reg(REG_TIME_STEP, 25'h1000000);
		write_reg(REG_STEPS, 25'd1);
		push_item(10'd7, STIM_MAX);
		push_item(10'd7, STIM_MAX);
		push_item(10'd8, STIM_MIN);
		push_item(10'd5, '0);
		drain();

		// largest step size, above one
		write_reg(REG_TIME_STEP, 25'h1FFFFFF);
		write_reg(REG_STEPS, 25'd5);
		push_item(10'd9, STIM_ONE);
		push_item(10'd1023, STIM_MIN);
		push_item(10'd2, 32'sh00C00000);
		drain();

		// most steps per item: all ones in the data, masked to 2047
		write_reg(REG_TIME_STEP, DT_RESET);
		write_reg(REG_STEPS, 25'h1FFFFFF);
		push_item(10'd11, 32'sh00800000);
		push_item(10'd3, '0);
		drain();

		// many steps, beyond the nominal range top
		write_reg(REG_TIME_STEP, 25'd16777);
		write_reg(REG_STEPS, 25'd1024);
		push_item(10'd12, STIM_ONE);
		drain();

		// writes to unused indexes must leave both registers alone
		write_reg(REG_STEPS, 25'd2);
		write_reg(REG_UNUSED_A, DT_W'($urandom()));
		write_reg(REG_UNUSED_B, DT_W'($urandom()));
		push_item(10'd11, '0);
		push_item(10'd12, '0);
		drain();

		// random batches; the last one runs without idling
		for (int b = 0; b < BATCHES; b++) begin
			if (b == BATCHES - 1)
				calm = 1'b1;
			write_reg(REG_TIME_STEP, random_dt());
			steps_word = DT_W'(($urandom() << STEPS_W)
			           | ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 4)));
			write_reg(REG_STEPS, steps_word);
			for (int i = 0; i < BATCH_ITEMS; i++)
				queued_stimuli.push_back(random_item());
			drain();
		end

		if (fail_count == 0 && awaited_states.size() == 0) begin
			$display("fitzhugh_nagumo_euler_cells verification clean");
		end else begin
			$display("fitzhugh_nagumo_euler_cells verification failed");
		end
		$finish;
	end

	// Guard against a hung handshake: well past the slowest correct run.
	initial begin
		#8_000_000;
		$display("fitzhugh_nagumo_euler_cells verification failed");
		$finish;
	end

endmodule
